// File: design/ssr_pkg.sv
package ssr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W = 4;
  localparam int COUNT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam int MAX_PATTERN_DEF = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

// File: design/ssr_fifo.sv
module ssr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] head_o,
  input  logic             pop_i
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: design/ssr_front.sv
module ssr_front #(
  parameter int MAX_PATTERN = 8,
  parameter int MAX_REPLACEMENT = 8,
  localparam int J = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT,
  localparam int NW = $clog2(J + 1),
  localparam int JOB_W = ssr_pkg::COUNT_W + 1 + NW + ssr_pkg::BYTE_W * J
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ssr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ssr_pkg::BYTE_W-1:0]       text_byte_i,
  input  logic                             byte_present_i,
  input  logic                             end_of_string_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output logic [JOB_W-1:0]                 q_data_o
);
  import ssr_pkg::*;

  localparam int N = MAX_PATTERN;
  localparam int R = MAX_REPLACEMENT;
  localparam int FW = $clog2(N + 1);

  logic [BYTE_W*N-1:0] pat_q;
  logic [BYTE_W*R-1:0] rep_q;
  logic [LEN_W-1:0]    plen_q, rlen_q;

  logic [BYTE_W-1:0]   win_q [N];
  logic [BYTE_W-1:0]   win_d [N];
  logic [FW-1:0]       fill_q, fill_d;
  logic [COUNT_W-1:0]  total_q, total_d;

  logic [BYTE_W-1:0]   wa [N];
  logic [FW-1:0]       plen, fa, keep, k;
  logic [NW-1:0]       rlen, n;
  logic                hit, match, accept;
  logic [COUNT_W-1:0]  tot_inc;
  logic [BYTE_W*J-1:0] jb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      rep_q  <= '0;
      plen_q <= '0;
      rlen_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PATTERN_BYTES:      pat_q  <= cfg_wdata_i[BYTE_W*N-1:0];
        REG_PATTERN_LENGTH:     plen_q <= cfg_wdata_i[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  rep_q  <= cfg_wdata_i[BYTE_W*R-1:0];
        REG_REPLACEMENT_LENGTH: rlen_q <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  always_comb begin
    plen = (plen_q > LEN_W'(N)) ? FW'(N) : FW'(plen_q);
    rlen = (rlen_q > LEN_W'(R)) ? NW'(R) : NW'(rlen_q);

    for (int i = 0; i < N; i++) begin
      wa[i] = win_q[i];
      if (byte_present_i && FW'(i) == fill_q) begin
        wa[i] = text_byte_i;
      end
    end
    fa   = fill_q + FW'(byte_present_i);
    keep = (plen == '0) ? '0 : plen - FW'(1);

    hit   = 1'b0;
    match = 1'b1;
    k     = '0;
    for (int i = 0; i < N; i++) begin
      if (FW'(i) < plen && wa[i] != pat_q[BYTE_W*i +: BYTE_W]) begin
        match = 1'b0;
      end
    end
    if (byte_present_i) begin
      if (plen == '0 || fa > plen) begin
        k = fa - keep;
      end else if (fa == plen) begin
        hit = match;
        k   = match ? '0 : FW'(1);
      end
    end

    for (int i = 0; i < N; i++) begin
      win_d[i] = wa[i];
      for (int j = 0; j < N; j++) begin
        if (FW'(j) == k && i + j < N) begin
          win_d[i] = wa[(i + j) % N];
        end
      end
    end

    for (int i = 0; i < J; i++) begin
      jb[BYTE_W*i +: BYTE_W] = '0;
      if (hit) begin
        if (i < R) begin
          jb[BYTE_W*i +: BYTE_W] = rep_q[BYTE_W*(i % R) +: BYTE_W];
        end
      end else if (i < N) begin
        jb[BYTE_W*i +: BYTE_W] = wa[i % N];
      end
    end

    if (hit) begin
      n = rlen;
    end else if (end_of_string_i) begin
      n = NW'(fa);
    end else begin
      n = NW'(k);
    end

    tot_inc = (hit && total_q != COUNT_MAX) ? total_q + COUNT_W'(1) : total_q;
    fill_d  = (hit || end_of_string_i) ? '0 : fa - k;
    total_d = end_of_string_i ? '0 : tot_inc;
  end

  assign q_push_o = accept && (n != '0 || end_of_string_i);
  assign q_data_o = {(end_of_string_i ? tot_inc : '0), end_of_string_i, n, jb};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      total_q <= '0;
    end else if (accept) begin
      fill_q  <= fill_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

endmodule

// File: design/ssr_back.sv
module ssr_back #(
  parameter int MAX_PATTERN = 8,
  parameter int MAX_REPLACEMENT = 8,
  localparam int J = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT,
  localparam int NW = $clog2(J + 1),
  localparam int JOB_W = ssr_pkg::COUNT_W + 1 + NW + ssr_pkg::BYTE_W * J
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  logic [JOB_W-1:0]              q_data_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ssr_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                          out_present_o,
  output logic                          out_last_o,
  output logic [ssr_pkg::COUNT_W-1:0]   replace_count_o
);
  import ssr_pkg::*;

  localparam int BW = BYTE_W * J;

  logic [BW-1:0]      jbytes;
  logic [NW-1:0]      jn;
  logic               jlast;
  logic [COUNT_W-1:0] jcnt;

  logic [NW-1:0]      idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]  byte_q, sel;
  logic               present_q, last_q;
  logic [COUNT_W-1:0] count_q;
  logic               load, done;

  assign jbytes = q_data_i[BW-1:0];
  assign jn     = q_data_i[BW +: NW];
  assign jlast  = q_data_i[BW + NW];
  assign jcnt   = q_data_i[BW + NW + 1 +: COUNT_W];

  always_comb begin
    sel = '0;
    for (int i = 0; i < J; i++) begin
      if (NW'(i) == idx_q) begin
        sel = jbytes[BYTE_W*i +: BYTE_W];
      end
    end
  end

  assign load    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign done    = (jn == '0) || (idx_q + NW'(1) >= jn);
  assign q_pop_o = load && done;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = done ? '0 : idx_q + NW'(1);
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q    <= (jn == '0) ? '0 : sel;
      present_q <= (jn != '0);
      last_q    <= jlast && done;
      count_q   <= (jlast && done) ? jcnt : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = byte_q;
  assign out_present_o   = present_q;
  assign out_last_o      = last_q;
  assign replace_count_o = count_q;

endmodule

// File: design/stream_substring_replacer.sv
// Channel   Direction  Handshake                 Payload
// config    in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
// text      in         in_valid_i / in_stall_o   text_byte_i, byte_present_i, end_of_string_i
// result    out        out_valid_o / out_stall_i out_byte_o, out_present_o, out_last_o,
//                                                replace_count_o
//
// One text transaction per cycle while not stalled; the front settles the window and its
// match in that cycle. A transaction that yields bytes or ends a string queues a job of up
// to max(MAX_PATTERN, MAX_REPLACEMENT) result bytes; the back sends one result per cycle,
// unless out_stall_i holds it, from an output register fed through the job queue.
// Reset clears lengths, fill, count and queue; window contents stay undefined until written.
// in_stall_o rises when the job queue is full; out_stall_i holds the output register.
module stream_substring_replacer #(
  parameter int MAX_PATTERN = ssr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = ssr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ssr_pkg::BYTE_W-1:0]     text_byte_i,
  input  logic                           byte_present_i,
  input  logic                           end_of_string_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ssr_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                           out_present_o,
  output logic                           out_last_o,
  output logic [ssr_pkg::COUNT_W-1:0]    replace_count_o
);
  import ssr_pkg::*;

  localparam int J = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int NW = $clog2(J + 1);
  localparam int JOB_W = COUNT_W + 1 + NW + BYTE_W * J;

  logic             q_push, q_full, q_valid, q_pop;
  logic [JOB_W-1:0] q_in, q_head;

  ssr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .text_byte_i     (text_byte_i),
    .byte_present_i  (byte_present_i),
    .end_of_string_i (end_of_string_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (q_in)
  );

  ssr_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .pop_i       (q_pop)
  );

  ssr_back #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_head),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .out_present_o   (out_present_o),
    .out_last_o      (out_last_o),
    .replace_count_o (replace_count_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_pop_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("job popped from an empty queue");

  a_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_present_o) |-> out_last_o)
    else $error("end-only result without last flag");

  a_count_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_last_o) |-> (replace_count_o == '0))
    else $error("replacement count on a non-final result");

endmodule

// File: verif/ssr_checker.sv
`timescale 1ns / 100ps
module ssr_checker
  import ssr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [BYTE_W-1:0]     text_byte_i,
  input  logic                  byte_present_i,
  input  logic                  end_of_string_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [BYTE_W-1:0]     out_byte_i,
  input  logic                  out_present_i,
  input  logic                  out_last_i,
  input  logic [COUNT_W-1:0]    replace_count_i,
  output int                    mismatch_count_o,
  output int                    results_owed_o
);

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               present;
    logic               last;
    logic [COUNT_W-1:0] count;
  } result_t;

  result_t               rewritten_q[$];
  logic [CFG_DATA_W-1:0] pattern_word;
  logic [LEN_W-1:0]      pattern_len_reg;
  logic [CFG_DATA_W-1:0] replacement_word;
  logic [LEN_W-1:0]      replacement_len_reg;
  logic [BYTE_W-1:0]     window [8];
  int                    window_fill;
  logic [COUNT_W-1:0]    replacements;

  function automatic result_t make_result(input logic [BYTE_W-1:0] data, input logic present);
    result_t r;
    r = '{data: data, present: present, last: 1'b0, count: '0};
    return r;
  endfunction

  task automatic release_oldest();
    int i;
    rewritten_q.push_back(make_result(window[0], 1'b1));
    for (i = 1; i < window_fill && i < 8; i++) window[i-1] = window[i];
    window_fill--;
  endtask

  task automatic rewrite_text(input logic [BYTE_W-1:0] text, input logic present,
                              input logic eos);
    int      plen;
    int      rlen;
    int      keep;
    int      first;
    int      i;
    bit      hit;
    result_t tail;
    first = rewritten_q.size();
    plen = (pattern_len_reg > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pattern_len_reg);
    rlen = (replacement_len_reg > MAX_REPLACEMENT_DEF) ? MAX_REPLACEMENT_DEF :
           int'(replacement_len_reg);
    if (present) begin
      if (window_fill < 8) begin
        window[window_fill] = text;
        window_fill++;
      end
      if (plen == 0 || window_fill > plen) begin
        keep = (plen == 0) ? 0 : plen - 1;
        while (window_fill > keep) release_oldest();
      end else if (window_fill == plen) begin
        hit = 1'b1;
        for (i = 0; i < plen; i++) begin
          if (window[i] != pattern_word[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          for (i = 0; i < rlen; i++) begin
            rewritten_q.push_back(make_result(replacement_word[8*i +: 8], 1'b1));
          end
          window_fill = 0;
          if (replacements != COUNT_MAX) replacements++;
        end else begin
          release_oldest();
        end
      end
    end
    if (eos) begin
      while (window_fill > 0) release_oldest();
      if (rewritten_q.size() == first) rewritten_q.push_back(make_result('0, 1'b0));
      tail = rewritten_q.pop_back();
      tail.last = 1'b1;
      tail.count = replacements;
      rewritten_q.push_back(tail);
      replacements = '0;
    end
  endtask

  task automatic flag_result(input string what, input result_t want, input result_t got);
    if (mismatch_count_o < 10) begin
      $display("%0t %s: expected byte %02h present %b last %b count %0d", $time, what,
               want.data, want.present, want.last, want.count);
      $display("%0t %s: got      byte %02h present %b last %b count %0d", $time, what,
               got.data, got.present, got.last, got.count);
    end
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      rewritten_q.delete();
      pattern_word = '0;
      pattern_len_reg = '0;
      replacement_word = '0;
      replacement_len_reg = '0;
      window_fill = 0;
      replacements = '0;
      mismatch_count_o = 0;
      results_owed_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{data: out_byte_i, present: out_present_i, last: out_last_i,
                count: replace_count_i};
        if (rewritten_q.size() == 0) begin
          flag_result("result with none expected", '0, got);
        end else begin
          want = rewritten_q.pop_front();
          if (got !== want) flag_result("result mismatch", want, got);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PATTERN_BYTES:      pattern_word = cfg_wdata_i;
          REG_PATTERN_LENGTH:     pattern_len_reg = cfg_wdata_i[LEN_W-1:0];
          REG_REPLACEMENT_BYTES:  replacement_word = cfg_wdata_i;
          REG_REPLACEMENT_LENGTH: replacement_len_reg = cfg_wdata_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        rewrite_text(text_byte_i, byte_present_i, end_of_string_i);
      end
      results_owed_o = rewritten_q.size();
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
module tb;
  import ssr_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS = 155;
  localparam int PHASE_ITEMS = 30;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [BYTE_W-1:0]     text_byte;
  logic                  byte_present;
  logic                  end_of_string;
  logic                  out_valid;
  logic                  out_stall;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_present;
  logic                  out_last;
  logic [COUNT_W-1:0]    replace_count;
  int                    mismatches;
  int                    results_owed;
  int                    idle_cycles = 0;
  int                    stall_left = 0;
  bit                    quiet = 1'b0;
  logic [BYTE_W-1:0]     alphabet [4];
  logic [CFG_DATA_W-1:0] pattern_word;
  int                    pattern_len;

  stream_substring_replacer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .text_byte_i     (text_byte),
    .byte_present_i  (byte_present),
    .end_of_string_i (end_of_string),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_byte_o      (out_byte),
    .out_present_o   (out_present),
    .out_last_o      (out_last),
    .replace_count_o (replace_count)
  );

  ssr_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .text_byte_i      (text_byte),
    .byte_present_i   (byte_present),
    .end_of_string_i  (end_of_string),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_byte_i       (out_byte),
    .out_present_i    (out_present),
    .out_last_i       (out_last),
    .replace_count_i  (replace_count),
    .mismatch_count_o (mismatches),
    .results_owed_o   (results_owed)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    if ($urandom_range(0, 9) < 6) return LEN_W'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0:       return LEN_W'(0);
      1:       return LEN_W'(1);
      2:       return LEN_W'(8);
      default: return LEN_W'(15);
    endcase
  endfunction

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall = 1'b0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  task automatic send_item(input logic [BYTE_W-1:0] b, input logic present, input logic eos);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_byte = b;
    byte_present = present;
    end_of_string = eos;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_config(input int plen_pick, input int rlen_pick);
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] rlen;
    int               i;
    plen = (plen_pick < 0) ? pick_length() : LEN_W'(plen_pick);
    rlen = (rlen_pick < 0) ? pick_length() : LEN_W'(rlen_pick);
    alphabet[0] = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
    for (i = 1; i < 4; i++) alphabet[i] = 8'($urandom);
    pattern_word = {$urandom, $urandom};
    for (i = 0; i < 8; i++) begin
      if (i < plen) pattern_word[8*i +: 8] = alphabet[$urandom_range(0, 3)];
    end
    pattern_len = (plen > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(plen);
    write_reg(REG_PATTERN_BYTES, pattern_word);
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(plen));
    write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
    write_reg(REG_REPLACEMENT_LENGTH, CFG_DATA_W'(rlen));
  endtask

  task automatic send_string(inout int sent);
    logic [BYTE_W-1:0] text_q[$];
    logic [LEN_W-1:0]  new_len;
    int                target;
    int                piece;
    int                n;
    int                i;
    int                k;
    bit                eos_on_byte;
    target = $urandom_range(0, 12);
    while (text_q.size() < target) begin
      piece = $urandom_range(0, 9);
      if (piece < 4) begin
        for (k = 0; k < pattern_len; k++) text_q.push_back(pattern_word[8*k +: 8]);
      end else if (piece < 6) begin
        n = $urandom_range(0, pattern_len);
        for (k = 0; k < n; k++) text_q.push_back(pattern_word[8*k +: 8]);
      end else if (piece < 9) begin
        text_q.push_back(alphabet[$urandom_range(0, 3)]);
      end else begin
        text_q.push_back(8'($urandom));
      end
    end
    eos_on_byte = (text_q.size() > 0) && ($urandom_range(0, 9) < 7);
    for (i = 0; i < text_q.size(); i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      if ($urandom_range(0, 24) == 0) drain();
      if (i == text_q.size() / 2 && $urandom_range(0, 7) == 0) begin
        drain();
        new_len = LEN_W'($urandom_range(0, 15));
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(new_len));
        pattern_len = (new_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(new_len);
      end
      send_item(text_q[i], 1'b1, eos_on_byte && i == text_q.size() - 1);
      sent++;
    end
    if (!eos_on_byte) begin
      send_item(8'($urandom), 1'b0, 1'b1);
      sent++;
    end
  endtask

  initial begin
    int                sent;
    int                start;
    int                phase;
    int                i;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_PATTERN_BYTES;
    cfg_wdata = '0;
    in_valid = 1'b0;
    text_byte = '0;
    byte_present = 1'b0;
    end_of_string = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // pass through with the reset configuration
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h33, 1'b1, 1'b1);
    send_item(8'hA5, 1'b0, 1'b1);

    drain();
    write_reg(REG_PATTERN_BYTES, 64'h6261);
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    write_reg(REG_REPLACEMENT_BYTES, 64'h5A5958);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd3);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // lengths above the maximum saturate
    drain();
    write_reg(REG_PATTERN_BYTES, '1);
    write_reg(REG_PATTERN_LENGTH, 64'd15);
    write_reg(REG_REPLACEMENT_BYTES, '0);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd15);
    for (i = 0; i < 8; i++) send_item(8'hFF, 1'b1, i == 7);

    // shorten the pattern while the window holds bytes
    drain();
    write_reg(REG_PATTERN_BYTES, 64'h34333231);
    write_reg(REG_PATTERN_LENGTH, 64'd4);
    write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
    send_item(8'h31, 1'b1, 1'b0);
    send_item(8'h32, 1'b1, 1'b0);
    send_item(8'h33, 1'b1, 1'b0);
    drain();
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    send_item(8'h31, 1'b1, 1'b1);
    send_item(8'h31, 1'b1, 1'b1);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      if (phase == 0) load_config(MAX_PATTERN_DEF, MAX_REPLACEMENT_DEF);
      else load_config(-1, -1);
      quiet = (phase == 2);
      start = sent;
      while (sent - start < PHASE_ITEMS && sent < RANDOM_ITEMS) send_string(sent);
      phase++;
    end
    quiet = 1'b0;
    drain();

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
